/* hdl/unescape_and_strip_quotes_defines.svh */
// assertion macros for the unescape and strip quotes block
// used by the checker; no other dependencies
`ifndef UNESCAPE_AND_STRIP_QUOTES_DEFINES_SVH
`define UNESCAPE_AND_STRIP_QUOTES_DEFINES_SVH

// clocked assertion, disabled while reset is held
`define USQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that is also checked through reset
`define USQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* hdl/usq_pkg.sv */
// shared types, constants and helper functions of the unescape and strip quotes block
// no dependencies
package usq_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned QCOUNT_W   = 3;
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam int unsigned Q_IDX_W    = $clog2(Q_DEPTH);
    localparam int unsigned NUM_W      = 2;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ESCAPE_CHAR  = 3'd0,
        CFG_QUOTE_COUNT  = 3'd1,
        CFG_QUOTE_CHAR_A = 3'd2,
        CFG_QUOTE_CHAR_B = 3'd3,
        CFG_QUOTE_CHAR_C = 3'd4,
        CFG_QUOTE_CHAR_D = 3'd5
    } t_cfg_addr;

    // register reset values
    localparam logic [BYTE_W-1:0]   RST_ESCAPE_CHAR  = 8'd92;
    localparam logic [QCOUNT_W-1:0] RST_QUOTE_COUNT  = 3'd2;
    localparam logic [BYTE_W-1:0]   RST_QUOTE_CHAR_A = 8'd34;
    localparam logic [BYTE_W-1:0]   RST_QUOTE_CHAR_B = 8'd39;
    localparam logic [BYTE_W-1:0]   RST_QUOTE_CHAR_C = 8'd0;
    localparam logic [BYTE_W-1:0]   RST_QUOTE_CHAR_D = 8'd0;

    typedef struct packed {
        logic [BYTE_W-1:0]   escape_char;
        logic [QCOUNT_W-1:0] quote_count;
        logic [BYTE_W-1:0]   quote_char_a;
        logic [BYTE_W-1:0]   quote_char_b;
        logic [BYTE_W-1:0]   quote_char_c;
        logic [BYTE_W-1:0]   quote_char_d;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last;
        logic              unclosed_quote;
    } t_result;

    // results of one processed item, handed to the output queue
    typedef struct packed {
        logic [NUM_W-1:0] num;
        t_result          r0;
        t_result          r1;
    } t_push;

    // slot is in use when quote_count reaches it; counts above four act as four
    function automatic logic is_quote_byte(t_cfg cfg, logic [BYTE_W-1:0] b);
        return (cfg.quote_count >= 3'd1 && b == cfg.quote_char_a)
            || (cfg.quote_count >= 3'd2 && b == cfg.quote_char_b)
            || (cfg.quote_count >= 3'd3 && b == cfg.quote_char_c)
            || (cfg.quote_count >= 3'd4 && b == cfg.quote_char_d);
    endfunction

    function automatic t_result byte_result(logic [BYTE_W-1:0] b);
        t_result r;
        r.out_byte       = b;
        r.byte_valid     = 1'b1;
        r.last           = 1'b0;
        r.unclosed_quote = 1'b0;
        return r;
    endfunction

endpackage

/* hdl/usq_in_if.sv */
// input channel: one string byte, an end marker or both per transfer
// depends on usq_pkg
interface usq_in_if;
    import usq_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              end_of_string;

    modport source (output valid, data_byte, has_byte, end_of_string, input ready);
    modport sink   (input valid, data_byte, has_byte, end_of_string, output ready);
    modport mon    (input valid, ready, data_byte, has_byte, end_of_string);
endinterface

/* hdl/usq_out_if.sv */
// output channel: one result per transfer
// depends on usq_pkg
interface usq_out_if;
    import usq_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic              unclosed_quote;

    modport source (output valid, out_byte, byte_valid, last, unclosed_quote, input ready);
    modport sink   (input valid, out_byte, byte_valid, last, unclosed_quote, output ready);
    modport mon    (input valid, ready, out_byte, byte_valid, last, unclosed_quote);
endinterface

/* hdl/usq_cfg_if.sv */
// configuration write channel: register index and write data
// depends on usq_pkg
interface usq_cfg_if;
    import usq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [BYTE_W-1:0]     data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
    modport mon    (input valid, ready, addr, data);
endinterface

/* hdl/usq_cfg_regs.sv */
// configuration register file: escape byte, quote count and quote slots
// depends on usq_pkg and usq_cfg_if
module usq_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    usq_cfg_if.sink       i_cfg,
    output usq_pkg::t_cfg o_cfg
);
    import usq_pkg::*;

    t_cfg r_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register write decode, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escape_char  <= RST_ESCAPE_CHAR;
            r_cfg.quote_count  <= RST_QUOTE_COUNT;
            r_cfg.quote_char_a <= RST_QUOTE_CHAR_A;
            r_cfg.quote_char_b <= RST_QUOTE_CHAR_B;
            r_cfg.quote_char_c <= RST_QUOTE_CHAR_C;
            r_cfg.quote_char_d <= RST_QUOTE_CHAR_D;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_addr'(i_cfg.addr))
                CFG_ESCAPE_CHAR:  r_cfg.escape_char  <= i_cfg.data;
                CFG_QUOTE_COUNT:  r_cfg.quote_count  <= i_cfg.data[QCOUNT_W-1:0];
                CFG_QUOTE_CHAR_A: r_cfg.quote_char_a <= i_cfg.data;
                CFG_QUOTE_CHAR_B: r_cfg.quote_char_b <= i_cfg.data;
                CFG_QUOTE_CHAR_C: r_cfg.quote_char_c <= i_cfg.data;
                CFG_QUOTE_CHAR_D: r_cfg.quote_char_d <= i_cfg.data;
                default: ;
            endcase
        end
    end
endmodule

/* hdl/usq_core.sv */
// input register, escape and quote state, and the per-item decode
// depends on usq_pkg and usq_in_if
module usq_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    usq_in_if.sink         i_in,
    input  usq_pkg::t_cfg  i_cfg,
    input  logic           i_room,
    output usq_pkg::t_push o_push
);
    import usq_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_has;
    logic              r_in_end;

    logic              r_esc;
    logic              r_inq;
    logic [BYTE_W-1:0] r_oq;
    logic              n_esc;
    logic              n_inq;
    logic [BYTE_W-1:0] n_oq;

    logic             accept;
    logic             process;
    logic [NUM_W-1:0] cnt;
    t_result          res0;
    t_result          res1;
    logic             is_q;

    // held item moves on when the output queue has room for two results
    assign process     = r_in_valid && i_room;
    assign i_in.ready  = !r_in_valid || process;
    assign accept      = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !process);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in.data_byte;
            r_in_has  <= i_in.has_byte;
            r_in_end  <= i_in.end_of_string;
        end
    end

    assign is_q = is_quote_byte(i_cfg, r_in_byte);

    // byte handling, then end of string handling
    always_comb begin
        n_esc = r_esc;
        n_inq = r_inq;
        n_oq  = r_oq;
        res0  = '0;
        res1  = '0;
        cnt   = '0;
        if (r_in_has) begin
            if (r_esc) begin
                n_esc = 1'b0;
                if (!(r_in_byte == i_cfg.escape_char || is_q)) begin
                    res0 = byte_result(i_cfg.escape_char);
                    res1 = byte_result(r_in_byte);
                    cnt  = 2'd2;
                end else begin
                    res0 = byte_result(r_in_byte);
                    cnt  = 2'd1;
                end
            end else if (r_in_byte == i_cfg.escape_char) begin
                n_esc = 1'b1;
            end else if (r_inq && r_in_byte == r_oq) begin
                n_inq = 1'b0;
                n_oq  = '0;
            end else if (!r_inq && is_q) begin
                n_inq = 1'b1;
                n_oq  = r_in_byte;
            end else begin
                res0 = byte_result(r_in_byte);
                cnt  = 2'd1;
            end
        end
        if (r_in_end) begin
            // a pending escape here means nothing was emitted yet
            if (n_esc) begin
                res0 = byte_result(i_cfg.escape_char);
                cnt  = 2'd1;
            end
            // status-only result: res0 is still all zero
            if (cnt == 2'd0) begin
                cnt = 2'd1;
            end
            if (cnt == 2'd2) begin
                res1.last           = 1'b1;
                res1.unclosed_quote = n_inq;
            end else begin
                res0.last           = 1'b1;
                res0.unclosed_quote = n_inq;
            end
            n_esc = 1'b0;
            n_inq = 1'b0;
            n_oq  = '0;
        end
    end

    // string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
            r_inq <= 1'b0;
            r_oq  <= '0;
        end else if (process) begin
            r_esc <= n_esc;
            r_inq <= n_inq;
            r_oq  <= n_oq;
        end
    end

    assign o_push.num = process ? cnt : '0;
    assign o_push.r0  = res0;
    assign o_push.r1  = res1;
endmodule

/* hdl/usq_out_q.sv */
// four-entry result queue feeding the output channel, head is the output register
// depends on usq_pkg and usq_out_if
module usq_out_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  usq_pkg::t_push i_push,
    output logic           o_room,
    usq_out_if.source      o_out
);
    import usq_pkg::*;

    t_result              r_q [Q_DEPTH];
    t_result              n_q [Q_DEPTH];
    logic [Q_CNT_W-1:0]   r_cnt;
    logic [Q_CNT_W-1:0]   n_cnt;
    logic [Q_CNT_W-1:0]   base;
    logic                 pop;

    assign o_room = r_cnt <= Q_CNT_W'(Q_DEPTH - 2);
    assign pop    = o_out.valid && o_out.ready;

    assign o_out.valid          = r_cnt != '0;
    assign o_out.out_byte       = r_q[0].out_byte;
    assign o_out.byte_valid     = r_q[0].byte_valid;
    assign o_out.last           = r_q[0].last;
    assign o_out.unclosed_quote = r_q[0].unclosed_quote;

    // shift out the head, then append new results behind what remains
    always_comb begin
        n_q  = r_q;
        base = r_cnt;
        if (pop) begin
            for (int i = 0; i < Q_DEPTH - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
            base = r_cnt - 1'b1;
        end
        if (i_push.num != '0) begin
            n_q[base[Q_IDX_W-1:0]] = i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            n_q[Q_IDX_W'(base + 1'b1)] = i_push.r1;
        end
        n_cnt = base + Q_CNT_W'(i_push.num);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end
endmodule

/* hdl/unescape_and_strip_quotes.sv */
// Escape and quote stripping filter for byte strings.
// i_in carries one item per transfer: a byte (has_byte) and/or an end marker
// (end_of_string). o_out carries results: a byte, or a status-only result
// (byte_valid 0) that closes a string with nothing left to emit. last marks
// the final result of a string and unclosed_quote flags a quote left open.
// i_cfg writes the escape byte, quote count and quote slots by index; write
// only while no string data is in flight.
// An accepted item waits in the input register, is decoded there, and its
// results are written into the result queue, whose head drives o_out.
// Throughput: one item per cycle while each item yields at most one result
// and the sink takes one result per cycle. An escaped plain byte yields two
// results; the four-entry result queue absorbs them, and i_in stalls only
// while more than two results wait.
// When the sink stalls, results collect in the queue; once more than two
// wait, the input register holds its item and i_in.ready falls. Reset empties
// the queue and input register, clears escape and quote state, and loads the
// register defaults.
// depends on usq_pkg, the channel interfaces, usq_cfg_regs, usq_core, usq_out_q
module unescape_and_strip_quotes (
    input  logic      i_clk,
    input  logic      i_rst_n,
    usq_in_if.sink    i_in,
    usq_out_if.source o_out,
    usq_cfg_if.sink   i_cfg
);
    import usq_pkg::*;

    t_cfg  cfg;
    t_push push;
    logic  room;

    // configuration registers
    usq_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // input register and decode
    usq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (cfg),
        .i_room  (room),
        .o_push  (push)
    );

    // result queue
    usq_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );
endmodule

/* hdl/usq_checker.sv */
// port-level checks for the unescape and strip quotes block, bound to the top level
// depends on usq_pkg and the assertion macro header
`include "unescape_and_strip_quotes_defines.svh"

module usq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [usq_pkg::BYTE_W-1:0] i_out_byte,
    input logic                       i_out_byte_valid,
    input logic                       i_out_last,
    input logic                       i_out_unclosed_quote
);
    // stalled result stays valid and keeps its byte and last flag
    `USQ_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) && $stable(i_out_last), "stalled result changed")

    // block comes out of reset empty and ready
    `USQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid && i_in_ready, "not idle after reset")

    // the error flag only closes a string
    `USQ_ASSERT(a_unclosed_last, i_clk, i_rst_n, i_out_valid && i_out_unclosed_quote |-> i_out_last, "unclosed_quote without last")

    // a status-only result ends a string and carries a zero byte
    `USQ_ASSERT(a_status_only, i_clk, i_rst_n, i_out_valid && !i_out_byte_valid |-> i_out_last && i_out_byte == 8'd0, "bad status-only result")
endmodule

bind unescape_and_strip_quotes usq_checker u_usq_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_ready           (i_in.ready),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_out_byte           (o_out.out_byte),
    .i_out_byte_valid     (o_out.byte_valid),
    .i_out_last           (o_out.last),
    .i_out_unclosed_quote (o_out.unclosed_quote)
);

/* tb/sv/tb_unescape_and_strip_quotes.sv */
// self-checking testbench for unescape_and_strip_quotes: strings of bytes go in, the
// stripped bytes are predicted in the bench and checked one by one as they come out
// depends on usq_pkg, usq_in_if, usq_out_if, usq_cfg_if and the block itself
module tb_unescape_and_strip_quotes;
    import usq_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned HOLD_LEN       = 300;

    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

    // register indexes past the last register, writes to them are dropped
    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_SPARE_HI = 3'd7;

    logic clk;
    logic rst_n;

    usq_in_if  in_ch();
    usq_out_if out_ch();
    usq_cfg_if cfg_ch();

    unescape_and_strip_quotes u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // bench copy of registers and string state
    t_cfg              cfg_shadow;
    logic              esc_pending;
    logic              quote_open;
    logic [BYTE_W-1:0] open_quote_byte;

    t_result results_due[$];

    int fail_count    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int cfg_settings  = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_ticket   = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    // clock, period 4
    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // quote slots in use, counts above four behave as four
    function automatic logic quote_in_use(logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] slots [Q_DEPTH];
        int unsigned used;
        slots[0] = cfg_shadow.quote_char_a;
        slots[1] = cfg_shadow.quote_char_b;
        slots[2] = cfg_shadow.quote_char_c;
        slots[3] = cfg_shadow.quote_char_d;
        used = (cfg_shadow.quote_count > Q_DEPTH) ? Q_DEPTH : cfg_shadow.quote_count;
        for (int i = 0; i < used; i++) begin
            if (slots[i] == b) return 1'b1;
        end
        return 1'b0;
    endfunction

    // work out the stripped output of one accepted item
    function automatic void predict_unescaped(logic [BYTE_W-1:0] b, logic has, logic eos);
        t_result outs[$];
        t_result r;
        if (has) begin
            if (esc_pending) begin
                esc_pending = 1'b0;
                if (!(b == cfg_shadow.escape_char || quote_in_use(b)))
                    outs.insert(outs.size(), byte_result(cfg_shadow.escape_char));
                outs.insert(outs.size(), byte_result(b));
            end else if (b == cfg_shadow.escape_char) begin
                esc_pending = 1'b1;
            end else if (quote_open && b == open_quote_byte) begin
                quote_open      = 1'b0;
                open_quote_byte = '0;
            end else if (!quote_open && quote_in_use(b)) begin
                quote_open      = 1'b1;
                open_quote_byte = b;
            end else begin
                outs.insert(outs.size(), byte_result(b));
            end
        end
        if (eos) begin
            // trailing escape comes out as itself
            if (esc_pending) begin
                esc_pending = 1'b0;
                outs.insert(outs.size(), byte_result(cfg_shadow.escape_char));
            end
            if (outs.size() == 0) begin
                r = '0;
                outs.insert(0, r);
            end
            r = outs[outs.size()-1];
            r.last           = 1'b1;
            r.unclosed_quote = quote_open;
            outs[outs.size()-1] = r;
            esc_pending     = 1'b0;
            quote_open      = 1'b0;
            open_quote_byte = '0;
        end
        foreach (outs[i]) results_due.insert(results_due.size(), outs[i]);
    endfunction

    // compare one output transfer with the oldest expectation
    task automatic check_result();
        t_result want;
        results_seen++;
        if (results_due.size() == 0) begin
            $error("result with none expected: out_byte %0h byte_valid %0b last %0b",
                   out_ch.out_byte, out_ch.byte_valid, out_ch.last);
            fail_count++;
            return;
        end
        want = results_due.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_ch.out_byte);
            fail_count++;
        end
        if (out_ch.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_ch.byte_valid);
            fail_count++;
        end
        if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            fail_count++;
        end
        if (out_ch.unclosed_quote !== want.unclosed_quote) begin
            $error("unclosed_quote: expected %0b, got %0b",
                   want.unclosed_quote, out_ch.unclosed_quote);
            fail_count++;
        end
    endtask

    // receiver: checks each transfer, stalls at random or for a long hold
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) check_result();
            if (hold_ticket != hold_seen) begin
                hold_seen    <= hold_ticket;
                hold_left    <= HOLD_LEN;
                out_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, results_due.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one item and wait for its transfer
    task automatic send_item(logic [BYTE_W-1:0] b, logic has, logic eos);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.has_byte      <= has;
        in_ch.end_of_string <= eos;
        do @(posedge clk); while (!in_ch.ready);
        predict_unescaped(b, has, eos);
        items_sent++;
    endtask

    // stop offering and let every expected result and in-flight item drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (addr)
            CFG_ESCAPE_CHAR:  cfg_shadow.escape_char  = data;
            CFG_QUOTE_COUNT:  cfg_shadow.quote_count  = data[QCOUNT_W-1:0];
            CFG_QUOTE_CHAR_A: cfg_shadow.quote_char_a = data;
            CFG_QUOTE_CHAR_B: cfg_shadow.quote_char_b = data;
            CFG_QUOTE_CHAR_C: cfg_shadow.quote_char_c = data;
            CFG_QUOTE_CHAR_D: cfg_shadow.quote_char_d = data;
            default: ;
        endcase
    endtask

    // write a full register set while the block is idle
    task automatic apply_config(logic [BYTE_W-1:0] esc, logic [BYTE_W-1:0] cnt,
                                logic [BYTE_W-1:0] qa, logic [BYTE_W-1:0] qb,
                                logic [BYTE_W-1:0] qc, logic [BYTE_W-1:0] qd);
        settle();
        write_reg(CFG_QUOTE_CHAR_D, qd);
        write_reg(CFG_QUOTE_CHAR_C, qc);
        write_reg(CFG_QUOTE_CHAR_B, qb);
        write_reg(CFG_QUOTE_CHAR_A, qa);
        write_reg(CFG_QUOTE_COUNT, cnt);
        write_reg(CFG_ESCAPE_CHAR, esc);
        cfg_settings++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return cfg_shadow.escape_char;
        if (r < 45) begin
            case ($urandom_range(3))
                0: return cfg_shadow.quote_char_a;
                1: return cfg_shadow.quote_char_b;
                2: return cfg_shadow.quote_char_c;
                default: return cfg_shadow.quote_char_d;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    // mostly well-formed strings with random content, some noise and cut strings
    task automatic feed_random_strings(int n);
        int   sent;
        int   len;
        logic closed;
        sent = 0;
        while (sent < n) begin
            len    = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(8);
            closed = 1'b0;
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(29) == 0)
                    send_item(8'($urandom_range(255)), 1'b0, 1'b0);
                closed = (k == len - 1) && ($urandom_range(1) == 1);
                send_item(pick_byte(), 1'b1, closed);
                sent++;
            end
            // most strings left without an end get a bare end marker, the rest run on into the next one
            if (!closed && $urandom_range(6) != 0) begin
                send_item(8'($urandom_range(255)), 1'b0, 1'b1);
                sent++;
            end
        end
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic set_idle(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // default registers: plain bytes, quotes, escapes and every way a string ends
    task automatic test_default_strings();
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(CH_DQUOTE, 1'b1, 1'b0);
        send_item("x", 1'b1, 1'b0);
        send_item(CH_SQUOTE, 1'b1, 1'b0);
        send_item(CH_DQUOTE, 1'b1, 1'b0);
        send_item(CH_SQUOTE, 1'b1, 1'b0);
        send_item(CH_SQUOTE, 1'b1, 1'b0);
        send_item(CH_BSLASH, 1'b1, 1'b0);
        send_item("n", 1'b1, 1'b0);
        send_item(CH_BSLASH, 1'b1, 1'b0);
        send_item(CH_BSLASH, 1'b1, 1'b0);
        send_item(CH_BSLASH, 1'b1, 1'b0);
        send_item(CH_DQUOTE, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item("a", 1'b1, 1'b1);
        send_item(CH_BSLASH, 1'b1, 1'b1);
        send_item(CH_BSLASH, 1'b1, 1'b0);
        send_item("q", 1'b1, 1'b1);
        send_item(CH_DQUOTE, 1'b1, 1'b1);
        send_item(CH_DQUOTE, 1'b1, 1'b0);
        send_item("z", 1'b1, 1'b1);
        send_item(CH_BSLASH, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h55, 1'b0, 1'b0);
    endtask

    // four slots, one of them holding zero, top escape byte
    task automatic test_zero_quote_slot();
        apply_config(8'hFF, 8'd4, 8'h00, 8'h01, 8'h7F, 8'h80);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        feed_random_strings(90);
    endtask

    // count above four acts as four: zero escape byte, then escape byte one with count five
    task automatic test_count_overflow();
        apply_config(8'h00, 8'd7, 8'hAA, 8'h55, 8'hF0, 8'h0F);
        send_item(8'h0F, 1'b1, 1'b0);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'h0F, 1'b1, 1'b1);
        feed_random_strings(90);
        apply_config(8'h01, 8'd5, 8'h02, 8'h03, 8'h04, 8'h05);
        feed_random_strings(60);
    endtask

    // no quote slots in use, spare indexes ignored
    task automatic test_no_quotes();
        apply_config(CH_BSLASH, 8'd0, CH_DQUOTE, CH_SQUOTE, 8'h00, 8'h00);
        write_reg(CFG_ADDR_SPARE_LO, 8'hFF);
        write_reg(CFG_ADDR_SPARE_HI, 8'h00);
        feed_random_strings(90);
    endtask

    // escape byte also sits in a quote slot, escape wins
    task automatic test_escape_is_quote();
        apply_config(CH_DQUOTE, 8'd1, CH_DQUOTE, CH_SQUOTE, 8'h00, 8'h00);
        send_item(CH_DQUOTE, 1'b1, 1'b0);
        send_item(CH_DQUOTE, 1'b1, 1'b1);
        feed_random_strings(90);
    endtask

    // random registers, slots often colliding with each other or the escape
    task automatic test_random_settings(int rounds);
        logic [BYTE_W-1:0] esc;
        logic [BYTE_W-1:0] q [Q_DEPTH];
        for (int k = 0; k < rounds; k++) begin
            esc = 8'($urandom_range(255));
            foreach (q[i])
                q[i] = ($urandom_range(3) == 0) ? esc : 8'(8'h20 + $urandom_range(15));
            apply_config(esc, 8'($urandom_range(7)), q[0], q[1], q[2], q[3]);
            feed_random_strings(70);
        end
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_output_backpressure();
        apply_config(CH_BSLASH, 8'd2, CH_DQUOTE, CH_SQUOTE, 8'h00, 8'h00);
        hold_ticket <= hold_ticket + 1;
        feed_random_strings(80);
    endtask

    initial begin
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = '0;
        in_ch.has_byte      = 1'b0;
        in_ch.end_of_string = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.addr         = CFG_ESCAPE_CHAR;
        cfg_ch.data         = '0;
        out_ch.ready        = 1'b0;
        cfg_shadow          = '{RST_ESCAPE_CHAR, RST_QUOTE_COUNT, RST_QUOTE_CHAR_A,
                                RST_QUOTE_CHAR_B, RST_QUOTE_CHAR_C, RST_QUOTE_CHAR_D};
        esc_pending         = 1'b0;
        quote_open          = 1'b0;
        open_quote_byte     = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(22, 52);
        test_default_strings();
        test_zero_quote_slot();
        test_count_overflow();
        set_idle(52, 22);
        test_no_quotes();
        test_escape_is_quote();
        test_random_settings(1);
        set_idle(0, 0);
        test_random_settings(2);
        test_output_backpressure();

        settle();
        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            fail_count++;
        end
        $display("sent %0d items under %0d register settings beyond reset, checked %0d results",
                 items_sent, cfg_settings, results_seen);
        $display("covered quotes, escapes, status-only ends and a long output stall");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* unescape_and_strip_quotes.f */
+incdir+hdl
hdl/usq_pkg.sv
hdl/usq_in_if.sv
hdl/usq_out_if.sv
hdl/usq_cfg_if.sv
hdl/usq_cfg_regs.sv
hdl/usq_core.sv
hdl/usq_out_q.sv
hdl/unescape_and_strip_quotes.sv
hdl/usq_checker.sv
tb/sv/tb_unescape_and_strip_quotes.sv
